// File: rtl/dtt_pkg.sv
// Shared constants, register codes and types for the detection track table.
`default_nettype none

package dtt_pkg;

   // Default table geometry.
   localparam int unsigned TABLE_DEPTH_DEF    = 16;
   localparam int unsigned MARKER_ID_BITS_DEF = 10;

   // Fixed widths of the item fields.
   localparam int unsigned ID_PORT_W = 10;
   localparam int unsigned POSE_W    = 16;
   localparam int unsigned HITS_W    = 8;
   localparam int unsigned SLOT_W    = 4;
   localparam int unsigned COUNT_W   = 5;

   // Register port geometry.
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned REG_W  = 8;

   // Register indexes, taken from address bits [3:2].
   typedef enum logic [1:0] {
      REG_VALIDATE_HITS      = 2'd0,
      REG_FORGET_VALIDATED   = 2'd1,
      REG_FORGET_UNVALIDATED = 2'd2
   } reg_index_type;

   // Reset values of the registers.
   localparam logic [REG_W-1:0] VALIDATE_HITS_RST      = 8'd5;
   localparam logic [REG_W-1:0] FORGET_VALIDATED_RST   = 8'd10;
   localparam logic [REG_W-1:0] FORGET_UNVALIDATED_RST = 8'd2;

   // Settings seen by every cell and by the top level.
   typedef struct packed {
      logic [REG_W-1:0] validate_hits;
      logic [REG_W-1:0] forget_validated;
      logic [REG_W-1:0] forget_unvalidated;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/dtt_csr.sv
// Register block holding the threshold and forget limits.
`default_nettype none

module dtt_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [dtt_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [dtt_pkg::DATA_W-1:0]   pwdata,
   output logic      [dtt_pkg::DATA_W-1:0]   prdata,
   output logic                              pready,
   output dtt_pkg::cfg_type                  cfg
);

   dtt_pkg::cfg_type cfg_ff;
   dtt_pkg::cfg_type cfg_in;
   logic             write_en;
   logic [1:0]       reg_idx;
   logic [dtt_pkg::REG_W-1:0] read_val;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign reg_idx  = paddr[3:2];

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_idx)
            dtt_pkg::REG_VALIDATE_HITS:      cfg_in.validate_hits      = pwdata[7:0];
            dtt_pkg::REG_FORGET_VALIDATED:   cfg_in.forget_validated   = pwdata[7:0];
            dtt_pkg::REG_FORGET_UNVALIDATED: cfg_in.forget_unvalidated = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.validate_hits      <= dtt_pkg::VALIDATE_HITS_RST;
         cfg_ff.forget_validated   <= dtt_pkg::FORGET_VALIDATED_RST;
         cfg_ff.forget_unvalidated <= dtt_pkg::FORGET_UNVALIDATED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      case (reg_idx)
         dtt_pkg::REG_VALIDATE_HITS:      read_val = cfg_ff.validate_hits;
         dtt_pkg::REG_FORGET_VALIDATED:   read_val = cfg_ff.forget_validated;
         dtt_pkg::REG_FORGET_UNVALIDATED: read_val = cfg_ff.forget_unvalidated;
         default:                         read_val = '0;
      endcase
   end

   assign prdata = {{(dtt_pkg::DATA_W-dtt_pkg::REG_W){1'b0}}, read_val};
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/dtt_cell.sv
// One table slot: holds an entry and passes the search token to the next slot.
`default_nettype none

module dtt_cell #(
   parameter int unsigned TABLE_DEPTH    = dtt_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned MARKER_ID_BITS = dtt_pkg::MARKER_ID_BITS_DEF,
   parameter int unsigned CELL_INDEX     = 0,
   parameter type         token_type     = logic,
   parameter type         write_type     = logic
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  dtt_pkg::cfg_type cfg,
   input  write_type       wr,
   input  token_type       tok_rx,
   output token_type       tok_tx
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   // Entry contents.
   logic                              valid_ff,  valid_in;
   logic                              seen_ff,   seen_in;
   logic [MARKER_ID_BITS-1:0]         marker_ff, marker_in;
   logic [dtt_pkg::HITS_W-1:0]        hits_ff,   hits_in;
   logic [dtt_pkg::HITS_W-1:0]        misses_ff, misses_in;
   logic signed [dtt_pkg::POSE_W-1:0] yaw_ff,    yaw_in;
   logic [dtt_pkg::POSE_W-1:0]        dist_ff,   dist_in;
   token_type                         tok_ff,    tok_in;

   logic                       validated;
   logic [dtt_pkg::HITS_W-1:0] limit;
   logic [dtt_pkg::HITS_W-1:0] miss_inc;
   logic                       evict;

   // Ageing terms for a frame end.
   always_comb begin
      validated = hits_ff >= cfg.validate_hits;
      limit     = validated ? cfg.forget_validated : cfg.forget_unvalidated;
      miss_inc  = (misses_ff == '1) ? misses_ff : misses_ff + 8'd1;
      evict     = valid_ff && !seen_ff && (miss_inc >= limit);
   end

   // Entry update and token hand-on.
   always_comb begin
      valid_in  = valid_ff;
      seen_in   = seen_ff;
      marker_in = marker_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      yaw_in    = yaw_ff;
      dist_in   = dist_ff;
      tok_in    = tok_rx;

      if (wr.en && (wr.slot == MY_IDX)) begin
         // A detection committed to this slot, either as an update or a new entry.
         valid_in  = 1'b1;
         seen_in   = 1'b1;
         marker_in = wr.marker_id;
         hits_in   = wr.hits;
         misses_in = '0;
         yaw_in    = wr.yaw;
         dist_in   = wr.dist_mm;
      end else if (tok_rx.active) begin
         if (tok_rx.frame_end) begin
            // Age an unseen entry and drop it once its miss count reaches its limit.
            seen_in = 1'b0;
            if (valid_ff && !seen_ff) begin
               misses_in = miss_inc;
               if (evict) begin
                  valid_in  = 1'b0;
                  hits_in   = '0;
                  misses_in = '0;
                  tok_in.evict_cnt = tok_rx.evict_cnt + CNT_W'(1);
               end
            end
            if (valid_ff && !evict) begin
               tok_in.valid_cnt = tok_rx.valid_cnt + CNT_W'(1);
            end
         end else begin
            // Look for a match, or note the first free slot.
            if (valid_ff) begin
               tok_in.valid_cnt = tok_rx.valid_cnt + CNT_W'(1);
               if (!tok_rx.hit && (marker_ff == tok_rx.marker_id)) begin
                  tok_in.hit      = 1'b1;
                  tok_in.hit_slot = MY_IDX;
                  tok_in.hit_hits = hits_ff;
               end
            end else if (!tok_rx.free) begin
               tok_in.free      = 1'b1;
               tok_in.free_slot = MY_IDX;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seen_ff  <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
         tok_ff   <= tok_in;
      end
   end

   // Entry payload.
   always_ff @(posedge clock) begin
      marker_ff <= marker_in;
      hits_ff   <= hits_in;
      misses_ff <= misses_in;
      yaw_ff    <= yaw_in;
      dist_ff   <= dist_in;
   end

   assign tok_tx = tok_ff;

endmodule

`default_nettype wire

// File: rtl/detection_track_table_top.sv
// Detection track table: a row of slot cells searched by a token passed cell to cell.
// An accepted item's token is registered in each cell in turn and then held for commit
// until the result register is free; no new item is taken before that commit.
// The result register frees the input side while a result is stalled.
// Reset (synchronous): all slots empty, registers at 5, 10 and 2, no result pending.
`default_nettype none

module detection_track_table_top #(
   parameter int unsigned TABLE_DEPTH    = dtt_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned MARKER_ID_BITS = dtt_pkg::MARKER_ID_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input items
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic [dtt_pkg::ID_PORT_W-1:0]       req_marker_id,
   input  wire logic signed [dtt_pkg::POSE_W-1:0]   req_yaw_angle,
   input  wire logic [dtt_pkg::POSE_W-1:0]          req_line_distance,
   // Result items
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [dtt_pkg::SLOT_W-1:0]               rsp_entry_slot,
   output logic [dtt_pkg::HITS_W-1:0]               rsp_hit_count,
   output logic                                     rsp_is_validated,
   output logic                                     rsp_newly_added,
   output logic                                     rsp_table_full,
   output logic [dtt_pkg::COUNT_W-1:0]              rsp_tracked_count,
   output logic [dtt_pkg::COUNT_W-1:0]              rsp_evicted_count,
   // Register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [dtt_pkg::ADDR_W-1:0]          paddr,
   input  wire logic [dtt_pkg::DATA_W-1:0]          pwdata,
   output logic      [dtt_pkg::DATA_W-1:0]          prdata,
   output logic                                     pready
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic                       active;
      logic                       frame_end;
      logic [MARKER_ID_BITS-1:0]  marker_id;
      logic                       hit;
      logic [IDX_W-1:0]           hit_slot;
      logic [dtt_pkg::HITS_W-1:0] hit_hits;
      logic                       free;
      logic [IDX_W-1:0]           free_slot;
      logic [CNT_W-1:0]           valid_cnt;
      logic [CNT_W-1:0]           evict_cnt;
   } token_type;

   typedef struct packed {
      logic                              en;
      logic [IDX_W-1:0]                  slot;
      logic [MARKER_ID_BITS-1:0]         marker_id;
      logic [dtt_pkg::HITS_W-1:0]        hits;
      logic signed [dtt_pkg::POSE_W-1:0] yaw;
      logic [dtt_pkg::POSE_W-1:0]        dist_mm;
   } write_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   dtt_pkg::cfg_type cfg;
   state_type        state_ff, state_in;
   token_type        pend_ff, pend_in;
   token_type        launch_tok;
   token_type        chain [TABLE_DEPTH+1];
   write_type        wr;

   logic signed [dtt_pkg::POSE_W-1:0] yaw_ff, yaw_in;
   logic [dtt_pkg::POSE_W-1:0]        dist_ff, dist_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dtt_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [dtt_pkg::HITS_W-1:0]        hits_ff, hits_in;
   logic                              vald_ff, vald_in;
   logic                              added_ff, added_in;
   logic                              full_ff, full_in;
   logic [dtt_pkg::COUNT_W-1:0]       tracked_ff, tracked_in;
   logic [dtt_pkg::COUNT_W-1:0]       evicted_ff, evicted_in;

   logic                              accept;
   logic                              out_free;
   logic [MARKER_ID_BITS+dtt_pkg::ID_PORT_W-1:0] id_ext;
   logic [dtt_pkg::HITS_W:0]          hit_inc;
   logic [dtt_pkg::HITS_W-1:0]        hit_sat;
   logic [IDX_W-1:0]                  tgt_slot;
   logic [IDX_W+dtt_pkg::SLOT_W-1:0]  slot_ext;
   logic [CNT_W-1:0]                  tracked_raw;
   logic [CNT_W+dtt_pkg::COUNT_W-1:0] tracked_ext;
   logic [CNT_W+dtt_pkg::COUNT_W-1:0] evicted_ext;

   // Register block.
   dtt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Item launch into the first cell.
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign id_ext    = {{MARKER_ID_BITS{1'b0}}, req_marker_id};

   always_comb begin
      launch_tok           = '0;
      launch_tok.active    = accept;
      launch_tok.frame_end = req_type;
      launch_tok.marker_id = id_ext[MARKER_ID_BITS-1:0];
   end

   assign chain[0] = launch_tok;

   // Row of slot cells.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      dtt_cell #(
         .TABLE_DEPTH    (TABLE_DEPTH),
         .MARKER_ID_BITS (MARKER_ID_BITS),
         .CELL_INDEX     (g),
         .token_type     (token_type),
         .write_type     (write_type)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg),
         .wr      (wr),
         .tok_rx  (chain[g]),
         .tok_tx  (chain[g+1])
      );
   end

   // Commit terms for the token that has left the last cell.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      hit_inc  = {1'b0, pend_ff.hit_hits} + 9'd1;
      hit_sat  = (hit_inc > {1'b0, cfg.validate_hits}) ? cfg.validate_hits
                                                       : hit_inc[dtt_pkg::HITS_W-1:0];
      tgt_slot = pend_ff.hit ? pend_ff.hit_slot : pend_ff.free_slot;

      wr.en        = (state_ff == ST_COMMIT) && out_free && !pend_ff.frame_end
                     && (pend_ff.hit || pend_ff.free);
      wr.slot      = tgt_slot;
      wr.marker_id = pend_ff.marker_id;
      wr.hits      = pend_ff.hit ? hit_sat : 8'd1;
      wr.yaw       = yaw_ff;
      wr.dist_mm   = dist_ff;
   end

   // Result fields for the committed item.
   always_comb begin
      slot_ext    = {{dtt_pkg::SLOT_W{1'b0}}, tgt_slot};
      tracked_raw = pend_ff.valid_cnt;
      if (!pend_ff.frame_end && !pend_ff.hit && pend_ff.free) begin
         tracked_raw = pend_ff.valid_cnt + CNT_W'(1);
      end
      tracked_ext = {{dtt_pkg::COUNT_W{1'b0}}, tracked_raw};
      evicted_ext = {{dtt_pkg::COUNT_W{1'b0}}, pend_ff.evict_cnt};
   end

   // Sequencer and result register.
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      yaw_in       = yaw_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      slot_in      = slot_ff;
      hits_in      = hits_ff;
      vald_in      = vald_ff;
      added_in     = added_ff;
      full_in      = full_ff;
      tracked_in   = tracked_ff;
      evicted_in   = evicted_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               yaw_in   = req_yaw_angle;
               dist_in  = req_line_distance;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (chain[TABLE_DEPTH].active) begin
               pend_in  = chain[TABLE_DEPTH];
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               slot_in      = '0;
               hits_in      = '0;
               vald_in      = 1'b0;
               added_in     = 1'b0;
               full_in      = 1'b0;
               tracked_in   = tracked_ext[dtt_pkg::COUNT_W-1:0];
               evicted_in   = '0;
               if (pend_ff.frame_end) begin
                  evicted_in = evicted_ext[dtt_pkg::COUNT_W-1:0];
               end else if (pend_ff.hit) begin
                  slot_in = slot_ext[dtt_pkg::SLOT_W-1:0];
                  hits_in = hit_sat;
                  vald_in = hit_sat >= cfg.validate_hits;
               end else if (pend_ff.free) begin
                  slot_in  = slot_ext[dtt_pkg::SLOT_W-1:0];
                  hits_in  = 8'd1;
                  vald_in  = cfg.validate_hits <= 8'd1;
                  added_in = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff    <= pend_in;
      yaw_ff     <= yaw_in;
      dist_ff    <= dist_in;
      slot_ff    <= slot_in;
      hits_ff    <= hits_in;
      vald_ff    <= vald_in;
      added_ff   <= added_in;
      full_ff    <= full_in;
      tracked_ff <= tracked_in;
      evicted_ff <= evicted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_slot    = slot_ff;
   assign rsp_hit_count     = hits_ff;
   assign rsp_is_validated  = vald_ff;
   assign rsp_newly_added   = added_ff;
   assign rsp_table_full    = full_ff;
   assign rsp_tracked_count = tracked_ff;
   assign rsp_evicted_count = evicted_ff;

endmodule

`default_nettype wire
